// File: hdl/alrm_pkg.sv
// Package for the alarm slot scheduler.
// Holds the table size, field widths, operation and status codes.
// No dependencies.
package alrm_pkg;

	localparam int SLOT_COUNT = 8;
	localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int MAX_FIRES  = 8;
	localparam int FIRE_W     = $clog2(MAX_FIRES + 1);
	localparam int ENTRY_W    = 100;

	localparam logic [31:0] DUE_MIN = 32'd1700000000;
	localparam logic [31:0] DUE_MAX = 32'd4102444800;

	localparam logic [11:0] GRACE_RST  = 12'd300;
	localparam logic [11:0] MINREP_RST = 12'd60;
	localparam logic [19:0] MAXREP_RST = 20'd604800;
	localparam logic [31:0] FLOOR_RST  = 32'd1700000000;

	typedef enum logic [1:0] {
		OP_SET    = 2'd0,
		OP_CANCEL = 2'd1,
		OP_TICK   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_GRACE  = 2'd0,
		REG_MINREP = 2'd1,
		REG_MAXREP = 2'd2,
		REG_FLOOR  = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_INVALID = 3'd1,
		ST_PAST    = 3'd2,
		ST_FULL    = 3'd3,
		ST_FIRED   = 3'd4,
		ST_DONE    = 3'd5
	} status_t;

	function automatic logic [2:0] slot_out(input logic [SLOT_W-1:0] idx);
		logic [SLOT_W+2:0] t;
		t = {3'b000, idx};
		return t[2:0];
	endfunction

endpackage

// File: hdl/alarm_slot_scheduler_core.sv
// Alarm slot scheduler: set, cancel and tick over a table of alarms.
// Slot data lives in a one-port synchronous memory; valid bits are flip-flops.
// Uses alrm_pkg.
// Each repeating alarm that advances on a tick goes through the serial 32-step divider
// and a multiply; a stalled result beat holds the work until it is taken.
// Throughput: one item is in work at a time; the next beat is taken after its final result.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
module alarm_slot_scheduler_core
	import alrm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// key[31:0], due_time[63:32], repeat_period[83:64], label_tag[99:84],
	// now_time[131:100], sink_ready[132], zeros above
	input  logic [135:0] s_tdata,
	// op[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// fired_key[31:0], fired_tag[47:32], fired_slot[50:48], zeros above
	output logic [55:0]  m_tdata,
	// status[2:0]
	output logic [2:0]   m_tuser,
	output logic         m_tlast,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_CHK  = 9'b000000010,
		S_RD   = 9'b000000100,
		S_EVAL = 9'b000001000,
		S_DIV  = 9'b000010000,
		S_MUL  = 9'b000100000,
		S_UPD  = 9'b001000000,
		S_WR   = 9'b010000000,
		S_FIN  = 9'b100000000
	} state_t;

	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOT_COUNT - 1);

	state_t state_q;
	logic [11:0] grace_q, minrep_q;
	logic [19:0] maxrep_q;
	logic [31:0] floor_q;
	logic [SLOT_COUNT-1:0] valid_q;

	op_t op_q;
	logic [31:0] key_q, due_q, now_q;
	logic [19:0] rep_q;
	logic [15:0] tag_q;
	logic ready_q;

	logic [SLOT_W-1:0] idx_q, wr_slot_q;
	logic [FIRE_W-1:0] n_q;
	status_t fin_st_q;
	logic [SLOT_W-1:0] fin_slot_q;
	logic [31:0] quo_q;
	logic [19:0] rem_q;
	logic [4:0] cnt_q;
	logic [52:0] prod_q;

	logic out_v_q;
	logic [55:0] out_d_q;
	logic [2:0] out_u_q;
	logic out_l_q;

	logic [ENTRY_W-1:0] mem [SLOT_COUNT];
	logic [ENTRY_W-1:0] rd_q;
	logic mem_we;
	logic [SLOT_W-1:0] mem_wa;
	logic [ENTRY_W-1:0] mem_wd;

	logic [31:0] in_key, in_due, in_now;
	logic [31:0] rd_key, rd_due, late;
	logic [19:0] rd_rep;
	logic [15:0] rd_tag;
	logic [20:0] trial;
	logic [53:0] sum;
	logic ob, any_free, in_win, bad, past, out_load;
	logic [SLOT_W-1:0] free_idx;
	op_t in_op;

	assign in_key = s_tdata[31:0];
	assign in_due = s_tdata[63:32];
	assign in_now = s_tdata[131:100];
	assign in_op  = op_t'(s_tuser);

	assign rd_key = rd_q[31:0];
	assign rd_due = rd_q[63:32];
	assign rd_rep = rd_q[83:64];
	assign rd_tag = rd_q[99:84];
	assign late   = now_q - rd_due;
	assign in_win = late <= {20'd0, grace_q};
	assign trial  = {rem_q, quo_q[31]};
	assign sum    = {22'd0, rd_due} + {1'b0, prod_q};
	assign ob     = !out_v_q || m_tready;

	assign out_load = ob && ((state_q == S_FIN) ||
		((state_q == S_EVAL) && (op_q == OP_TICK) && valid_q[idx_q] && (rd_due <= now_q) &&
		in_win && ready_q && (n_q < FIRE_W'(MAX_FIRES))));

	assign bad = (key_q == 32'd0) || (due_q < DUE_MIN) || (due_q > DUE_MAX) ||
		(rep_q > maxrep_q) || ((rep_q != 20'd0) && (rep_q < {8'd0, minrep_q}));
	assign past = (now_q > floor_q) && (due_q <= now_q);

	always_comb begin
		any_free = 1'b0;
		free_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				any_free = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = {rd_tag, rd_rep, sum[31:0], rd_key};
		if (state_q == S_WR) begin
			mem_we = 1'b1;
			mem_wa = wr_slot_q;
			mem_wd = {tag_q, rep_q, due_q, key_q};
		end else if (state_q == S_UPD && sum[53:32] == 22'd0) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (state_q == S_RD) rd_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grace_q  <= GRACE_RST;
			minrep_q <= MINREP_RST;
			maxrep_q <= MAXREP_RST;
			floor_q  <= FLOOR_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_GRACE:  grace_q  <= cfg_data[11:0];
				REG_MINREP: minrep_q <= cfg_data[11:0];
				REG_MAXREP: maxrep_q <= cfg_data[19:0];
				REG_FLOOR:  floor_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			out_v_q <= 1'b0;
			idx_q   <= '0;
			n_q     <= '0;
		end else begin
			if (out_v_q && m_tready && !out_load) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q    <= in_op;
						key_q   <= in_key;
						due_q   <= in_due;
						rep_q   <= s_tdata[83:64];
						tag_q   <= s_tdata[99:84];
						now_q   <= in_now;
						ready_q <= s_tdata[132];
						idx_q   <= '0;
						n_q     <= '0;
						fin_slot_q <= '0;
						case (in_op)
							OP_SET: state_q <= S_CHK;
							OP_CANCEL: begin
								if (in_key == 32'd0) begin
									fin_st_q <= ST_INVALID;
									state_q  <= S_FIN;
								end else begin
									fin_st_q <= ST_OK;
									state_q  <= S_RD;
								end
							end
							OP_TICK: begin
								fin_st_q <= ST_DONE;
								state_q  <= (in_now > floor_q) ? S_RD : S_FIN;
							end
							default: begin
								fin_st_q <= ST_INVALID;
								state_q  <= S_FIN;
							end
						endcase
					end
				end
				S_CHK: begin
					if (bad) begin
						fin_st_q <= ST_INVALID;
						state_q  <= S_FIN;
					end else if (past) begin
						fin_st_q <= ST_PAST;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_EVAL;
				S_EVAL: begin
					case (op_q)
						OP_SET: begin
							if (valid_q[idx_q] && rd_key == key_q) begin
								wr_slot_q <= idx_q;
								state_q   <= S_WR;
							end else if (idx_q == LAST_IDX) begin
								if (any_free) begin
									wr_slot_q <= free_idx;
									state_q   <= S_WR;
								end else begin
									fin_st_q <= ST_FULL;
									state_q  <= S_FIN;
								end
							end else begin
								idx_q   <= idx_q + 1'b1;
								state_q <= S_RD;
							end
						end
						OP_CANCEL: begin
							if (valid_q[idx_q] && rd_key == key_q) valid_q[idx_q] <= 1'b0;
							if (idx_q == LAST_IDX) state_q <= S_FIN;
							else begin
								idx_q   <= idx_q + 1'b1;
								state_q <= S_RD;
							end
						end
						default: begin
							if (!valid_q[idx_q] || rd_due > now_q ||
								(in_win && (!ready_q || n_q >= FIRE_W'(MAX_FIRES)))) begin
								if (idx_q == LAST_IDX) state_q <= S_FIN;
								else begin
									idx_q   <= idx_q + 1'b1;
									state_q <= S_RD;
								end
							end else if (!in_win || ob) begin
								if (in_win) begin
									out_v_q <= 1'b1;
									out_d_q <= {5'd0, slot_out(idx_q), rd_tag, rd_key};
									out_u_q <= ST_FIRED;
									out_l_q <= 1'b0;
									n_q     <= n_q + 1'b1;
								end
								if (rd_rep != 20'd0) begin
									quo_q   <= late;
									rem_q   <= '0;
									cnt_q   <= '0;
									state_q <= S_DIV;
								end else begin
									valid_q[idx_q] <= 1'b0;
									if (idx_q == LAST_IDX) state_q <= S_FIN;
									else begin
										idx_q   <= idx_q + 1'b1;
										state_q <= S_RD;
									end
								end
							end
						end
					endcase
				end
				S_DIV: begin
					if (trial >= {1'b0, rd_rep}) begin
						rem_q <= 20'(trial - {1'b0, rd_rep});
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= trial[19:0];
						quo_q <= {quo_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'd31) state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= ({1'b0, quo_q} + 33'd1) * rd_rep;
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (sum[53:32] != 22'd0) valid_q[idx_q] <= 1'b0;
					if (idx_q == LAST_IDX) state_q <= S_FIN;
					else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_WR: begin
					valid_q[wr_slot_q] <= 1'b1;
					fin_st_q   <= ST_OK;
					fin_slot_q <= wr_slot_q;
					state_q    <= S_FIN;
				end
				S_FIN: begin
					if (ob) begin
						out_v_q <= 1'b1;
						out_d_q <= {5'd0, slot_out(fin_slot_q), 48'd0};
						out_u_q <= fin_st_q;
						out_l_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_d_q;
	assign m_tuser  = out_u_q;
	assign m_tlast  = out_l_q;

endmodule

// File: hdl/alrm_chk.sv
// Port checker for the alarm slot scheduler, bound to the top level.
// Uses alrm_pkg for the status codes.
module alrm_chk
	import alrm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);

	a_fire_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_FIRED |-> !m_tlast)
		else $error("fired beat marked last");

	a_other_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_FIRED |-> m_tlast)
		else $error("final beat not marked last");

	a_fire_key: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_FIRED |-> m_tdata[31:0] != 32'd0)
		else $error("fired beat with zero key");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled beat changed");

endmodule

bind alarm_slot_scheduler_core alrm_chk u_alrm_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// File: tb/sv/tb_alarm_slot_scheduler_core.sv
// Testbench for the alarm slot scheduler core: directed and random set, cancel and
// tick beats, checked against an in-bench model of the alarm table.
// Depends on alrm_pkg and alarm_slot_scheduler_core.
`timescale 1ns / 100ps

module tb_alarm_slot_scheduler_core;
	import alrm_pkg::*;

	typedef struct packed {
		status_t     status;
		logic [31:0] key;
		logic [15:0] tag;
		logic [2:0]  slot;
		logic        last;
	} alarm_res_t;

	typedef struct {
		op_t         op;
		logic [31:0] key;
		logic [31:0] due;
		logic [19:0] rep;
		logic [15:0] tag;
		logic [31:0] now;
		logic        ready;
		bit          has_exp;
		status_t     exp_status;
	} alarm_cmd_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [135:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [55:0]  m_tdata;
	logic [2:0]   m_tuser;
	logic         m_tlast;
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_index = '0;
	logic [31:0]  cfg_data = '0;

	alarm_slot_scheduler_core i_dut (.*);

	always #5 clk = ~clk;

	logic [11:0] grace_win;
	logic [11:0] rep_min;
	logic [19:0] rep_max;
	logic [31:0] sync_floor;
	bit          tbl_valid [SLOT_COUNT];
	logic [31:0] tbl_key [SLOT_COUNT];
	logic [31:0] tbl_due [SLOT_COUNT];
	logic [19:0] tbl_rep [SLOT_COUNT];
	logic [15:0] tbl_tag [SLOT_COUNT];

	alarm_res_t pending_res[$];
	int         mismatches = 0;
	int         idle_cycles = 0;
	bit         timed_out = 0;
	int         hold_off = 0;
	bit         hold_req = 0;
	bit         hold_done = 0;
	bit         calm = 0;
	int         slot_err[$];

	function automatic alarm_res_t mk(status_t st, logic [31:0] k, logic [15:0] t,
			logic [2:0] s, logic l);
		alarm_res_t r;
		r.status = st; r.key = k; r.tag = t; r.slot = s; r.last = l;
		return r;
	endfunction

	function automatic void queue_result(alarm_res_t r);
		pending_res.insert(pending_res.size(), r);
	endfunction

	task automatic predict_alarms(input alarm_cmd_t c);
		int slot;
		int fires;
		logic [31:0] late;
		logic [63:0] nxt;
		slot = -1;
		fires = 0;
		case (c.op)
			OP_SET: begin
				if (c.key == 0 || c.due < DUE_MIN || c.due > DUE_MAX || c.rep > rep_max ||
						(c.rep != 0 && c.rep < {8'd0, rep_min})) begin
					queue_result(mk(ST_INVALID, 0, 0, 0, 1));
				end else if (c.now > sync_floor && c.due <= c.now) begin
					queue_result(mk(ST_PAST, 0, 0, 0, 1));
				end else begin
					for (int s = 0; s < SLOT_COUNT && slot < 0; s++)
						if (tbl_valid[s] && tbl_key[s] == c.key) slot = s;
					for (int s = 0; s < SLOT_COUNT && slot < 0; s++)
						if (!tbl_valid[s]) slot = s;
					if (slot < 0) begin
						queue_result(mk(ST_FULL, 0, 0, 0, 1));
					end else begin
						tbl_valid[slot] = 1; tbl_key[slot] = c.key; tbl_due[slot] = c.due;
						tbl_rep[slot] = c.rep; tbl_tag[slot] = c.tag;
						queue_result(mk(ST_OK, 0, 0, slot[2:0], 1));
					end
				end
			end
			OP_CANCEL: begin
				if (c.key == 0) begin
					queue_result(mk(ST_INVALID, 0, 0, 0, 1));
				end else begin
					for (int s = 0; s < SLOT_COUNT; s++)
						if (tbl_valid[s] && tbl_key[s] == c.key) tbl_valid[s] = 0;
					queue_result(mk(ST_OK, 0, 0, 0, 1));
				end
			end
			OP_TICK: begin
				if (c.now > sync_floor) begin
					for (int s = 0; s < SLOT_COUNT; s++) begin
						if (!tbl_valid[s] || tbl_due[s] > c.now) continue;
						late = c.now - tbl_due[s];
						if (late <= grace_win && (!c.ready || fires >= MAX_FIRES)) continue;
						if (late <= grace_win) begin
							queue_result(mk(ST_FIRED, tbl_key[s], tbl_tag[s], s[2:0], 0));
							fires++;
						end
						if (tbl_rep[s] != 0) begin
							nxt = 64'(tbl_due[s]) + (64'(late) / tbl_rep[s] + 1) * tbl_rep[s];
							if (nxt > 64'hFFFF_FFFF) tbl_valid[s] = 0;
							else tbl_due[s] = nxt[31:0];
						end else begin
							tbl_valid[s] = 0;
						end
					end
				end
				queue_result(mk(ST_DONE, 0, 0, 0, 1));
			end
			default: queue_result(mk(ST_INVALID, 0, 0, 0, 1));
		endcase
	endtask

	task automatic send_beat(input alarm_cmd_t c);
		if (!calm) begin
			while ($urandom_range(99) < 33) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser <= c.op;
		s_tdata <= {3'b0, c.ready, c.now, c.tag, c.rep, c.due, c.key};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (c.has_exp) slot_err.insert(slot_err.size(), c.exp_status);
		else slot_err.insert(slot_err.size(), -1);
		predict_alarms(c);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_res.size() != 0 && !timed_out) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_GRACE:  grace_win = val[11:0];
			REG_MINREP: rep_min = val[11:0];
			REG_MAXREP: rep_max = val[19:0];
			default:    sync_floor = val;
		endcase
	endtask

	function automatic alarm_cmd_t row(op_t op, logic [31:0] k, logic [31:0] d,
			logic [19:0] r, logic [15:0] t, logic [31:0] n, logic rdy,
			bit he = 0, status_t es = ST_OK);
		alarm_cmd_t c;
		c.op = op; c.key = k; c.due = d; c.rep = r; c.tag = t; c.now = n; c.ready = rdy;
		c.has_exp = he; c.exp_status = es;
		return c;
	endfunction

	function automatic alarm_cmd_t random_cmd(logic [31:0] base);
		alarm_cmd_t c;
		int pick;
		pick = $urandom_range(99);
		c = row(OP_TICK, $urandom_range(1, 6), base + $urandom_range(0, 400),
			$urandom_range(0, 3) == 0 ? 20'd0 : 20'($urandom_range(60, 500)),
			16'($urandom), base + $urandom_range(0, 1000), $urandom_range(0, 3) != 0);
		if (pick < 40) c.op = OP_SET;
		else if (pick < 50) c.op = OP_CANCEL;
		else if (pick < 90) c.op = OP_TICK;
		else begin
			c.op = op_t'(2'($urandom_range(3)));
			c.key = $urandom;
			c.due = $urandom;
			c.rep = 20'($urandom);
			c.now = $urandom;
		end
		return c;
	endfunction

	// Result side: random stalls (none while calm) plus one long hold-off requested by the stimulus.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			m_tready  <= 1'b0;
			hold_off  <= 400;
			hold_done <= 1'b1;
		end else if (hold_off > 0) begin
			m_tready <= 1'b0;
			hold_off <= hold_off - 1;
		end else begin
			m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 33);
		end
	end

	always @(posedge clk) begin
		alarm_res_t got;
		alarm_res_t want;
		int es;
		if (arst_n && m_tvalid && m_tready) begin
			got = mk(status_t'(m_tuser), m_tdata[31:0], m_tdata[47:32], m_tdata[50:48], m_tlast);
			if (pending_res.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected beat %p", got);
			end else begin
				want = pending_res.pop_front();
				if (want.last && slot_err.size() != 0) begin
					es = slot_err.pop_front();
					if (es >= 0 && want.status != status_t'(es)) begin
						mismatches++;
						if (mismatches <= 10) $display("table status %0d model %0d", es, want.status);
					end
				end
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000 && !timed_out) begin
			timed_out = 1;
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		alarm_cmd_t tbl[$];
		logic [31:0] t0;
		grace_win = GRACE_RST; rep_min = MINREP_RST; rep_max = MAXREP_RST;
		sync_floor = FLOOR_RST;
		for (int s = 0; s < SLOT_COUNT; s++) tbl_valid[s] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		t0 = 32'd1800000000;
		tbl = '{
			row(OP_SET, 0, t0, 0, 0, 0, 0, 1, ST_INVALID),
			row(OP_SET, 1, 32'd1699999999, 0, 0, 0, 0, 1, ST_INVALID),
			row(OP_SET, 1, DUE_MAX + 1, 0, 0, 0, 0, 1, ST_INVALID),
			row(OP_SET, 1, t0, 20'd604801, 0, 0, 0, 1, ST_INVALID),
			row(OP_SET, 1, t0, 20'd59, 0, 0, 0, 1, ST_INVALID),
			row(OP_SET, 1, t0, 0, 0, t0, 0, 1, ST_PAST),
			row(OP_SET, 32'hFFFF_FFFF, DUE_MAX, 20'd604800, 16'hFFFF, 0, 0, 1, ST_OK),
			row(OP_SET, 1, DUE_MIN, 0, 16'h1234, 0, 0),
			row(OP_SET, 2, t0, 20'd60, 16'h00AA, t0 - 10, 0),
			row(OP_SET, 3, t0, 20'd1000, 16'h5555, 0, 0),
			row(OP_SET, 4, 32'hFFFF_FF00, 20'd600, 16'hAAAA, 0, 0),
			row(OP_SET, 5, t0 + 5, 0, 16'h0001, 0, 0),
			row(OP_SET, 6, t0 + 6, 0, 16'h0002, 0, 0),
			row(OP_SET, 7, t0 + 7, 0, 16'h0003, 0, 0),
			row(OP_SET, 8, t0 + 8, 0, 16'h0004, 0, 0, 1, ST_OK),
			row(OP_SET, 9, t0 + 9, 0, 16'h0005, 0, 0, 1, ST_FULL),
			row(OP_CANCEL, 0, 0, 0, 0, 0, 0, 1, ST_INVALID),
			row(OP_CANCEL, 9, 0, 0, 0, 0, 0, 1, ST_OK),
			row(OP_TICK, 0, 0, 0, 0, 32'd1700000000, 1, 1, ST_DONE),
			row(OP_NONE, 0, 0, 0, 0, 0, 0, 1, ST_INVALID),
			row(OP_TICK, 0, 0, 0, 0, t0 + 10, 0),
			row(OP_TICK, 0, 0, 0, 0, t0 + 100, 1),
			row(OP_TICK, 0, 0, 0, 0, 32'hFFFF_FF20, 1),
			row(OP_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF, 1),
			row(OP_CANCEL, 32'hFFFF_FFFF, 0, 0, 0, 0, 0)
		};
		foreach (tbl[i]) send_beat(tbl[i]);
		drain_results();

		// Every slot becomes due at once: the fire limit and full table are reached.
		write_reg(REG_GRACE, 12'd4095);
		write_reg(REG_MINREP, 12'd1);
		write_reg(REG_MAXREP, 20'hFFFFF);
		write_reg(REG_FLOOR, 32'd0);
		for (int s = 0; s < SLOT_COUNT; s++)
			send_beat(row(OP_SET, 100 + s, t0, 20'(s), 16'(s), 0, 0));
		send_beat(row(OP_TICK, 0, 0, 0, 0, t0 + 3, 1));
		send_beat(row(OP_TICK, 0, 0, 0, 0, t0 + 40, 1));
		send_beat(row(OP_SET, 1, t0, 20'hFFFFF, 0, 0, 0));
		send_beat(row(OP_SET, 1, t0, 20'd1, 0, 0, 0));
		drain_results();

		write_reg(REG_GRACE, 12'd0);
		write_reg(REG_MINREP, 12'd3600);
		write_reg(REG_MAXREP, 20'd3600);
		write_reg(REG_FLOOR, 32'hFFFF_FFFF);
		send_beat(row(OP_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF, 1));
		for (int s = 0; s < SLOT_COUNT; s++)
			send_beat(row(OP_CANCEL, 100 + s, 0, 0, 0, 0, 0));
		send_beat(row(OP_CANCEL, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
		send_beat(row(OP_CANCEL, 1, 0, 0, 0, 0, 0));
		drain_results();

		write_reg(REG_GRACE, 12'd300);
		write_reg(REG_MINREP, 12'd60);
		write_reg(REG_MAXREP, 20'd604800);
		write_reg(REG_FLOOR, 32'd1700000000);
		hold_req = 1;
		for (int i = 0; i < 60; i++) send_beat(random_cmd(t0 + i * 50));
		drain_results();

		write_reg(REG_GRACE, 12'd30);
		calm = 1;
		for (int i = 0; i < 40; i++) send_beat(random_cmd(t0 + 5000 + i * 40));
		calm = 0;
		for (int i = 0; i < 30; i++) send_beat(random_cmd(t0 + 9000 + i * 30));
		drain_results();

		if (mismatches == 0 && pending_res.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: filelist.f
hdl/alrm_pkg.sv
hdl/alarm_slot_scheduler_core.sv
hdl/alrm_chk.sv
tb/sv/tb_alarm_slot_scheduler_core.sv
